/* rtl/a64dpi_pkg.sv */
// Package of the A64 data-processing immediate decoder: group and opcode codes,
// the packed result item and the logical-immediate mask expansion.
// Depends on nothing.
`default_nettype none

package a64dpi_pkg;

  localparam int unsigned ModeW = 3;
  localparam int unsigned InstrW = 32;
  localparam int unsigned OpcodeW = 5;
  localparam int unsigned RegW = 5;
  localparam int unsigned ImmW = 64;
  localparam int unsigned FieldW = 6;
  localparam int unsigned TagAdjW = 4;
  localparam int unsigned OutDataW = 120;

  localparam logic [ModeW-1:0] ModeAddr = 3'd0;
  localparam logic [ModeW-1:0] ModeAddSub = 3'd1;
  localparam logic [ModeW-1:0] ModeAddSubTag = 3'd2;
  localparam logic [ModeW-1:0] ModeLogical = 3'd3;
  localparam logic [ModeW-1:0] ModeMoveWide = 3'd4;
  localparam logic [ModeW-1:0] ModeBitfield = 3'd5;
  localparam logic [ModeW-1:0] ModeExtract = 3'd6;

  localparam logic [OpcodeW-1:0] OpAdr = 5'd0;
  localparam logic [OpcodeW-1:0] OpAdrp = 5'd1;
  localparam logic [OpcodeW-1:0] OpAdd = 5'd2;
  localparam logic [OpcodeW-1:0] OpAddg = 5'd6;
  localparam logic [OpcodeW-1:0] OpSubg = 5'd7;
  localparam logic [OpcodeW-1:0] OpAnd = 5'd8;
  localparam logic [OpcodeW-1:0] OpMovn = 5'd12;
  localparam logic [OpcodeW-1:0] OpMovz = 5'd13;
  localparam logic [OpcodeW-1:0] OpMovk = 5'd14;
  localparam logic [OpcodeW-1:0] OpSbfm = 5'd15;
  localparam logic [OpcodeW-1:0] OpExtr = 5'd18;

  localparam logic [FieldW-1:0] AddSubShift = 6'd12;

  // Declared from the top bit down so that valid_res sits in bit 0.
  typedef struct packed {
    logic [FieldW-1:0]  size_field;
    logic [FieldW-1:0]  rotate_field;
    logic [TagAdjW-1:0] tag_adjust;
    logic [FieldW-1:0]  tag_offset;
    logic [FieldW-1:0]  shift_amount;
    logic [ImmW-1:0]    immediate;
    logic [RegW-1:0]    second_src_reg;
    logic [RegW-1:0]    first_src_reg;
    logic [RegW-1:0]    dest_reg;
    logic               wide_operands;
    logic [OpcodeW-1:0] opcode;
    logic               valid_res;
  } result_t;

  typedef struct packed {
    logic            ok;
    logic [ImmW-1:0] mask;
  } bitmask_t;

  // Element size from N:NOT(imms), a run of S+1 ones replicated at that period,
  // then the whole word rotated right by R (rotation commutes with replication).
  function automatic bitmask_t decode_bit_masks(input logic n, input logic [5:0] imms,
                                                input logic [5:0] immr, input logic wide);
    bitmask_t   res;
    logic [6:0] pat;
    logic [5:0] levels;
    logic [5:0] s;
    logic [5:0] r;
    logic [ImmW-1:0] rep;
    logic [5:0] idx;
    pat = {n, ~imms};
    levels = 6'd0;
    if (pat[6]) levels = 6'd63;
    else if (pat[5]) levels = 6'd31;
    else if (pat[4]) levels = 6'd15;
    else if (pat[3]) levels = 6'd7;
    else if (pat[2]) levels = 6'd3;
    else if (pat[1]) levels = 6'd1;
    s = imms & levels;
    r = immr & levels;
    for (int i = 0; i < ImmW; i++) begin
      idx = 6'(i) & levels;
      rep[i] = (idx <= s);
    end
    res.mask = (rep >> r) | (rep << (7'd64 - {1'b0, r}));
    if (!wide) res.mask[ImmW-1:ImmW/2] = '0;
    res.ok = (pat[6:1] != 6'd0) && (s != levels) && (wide || !pat[6]);
    return res;
  endfunction

endpackage

`default_nettype wire

/* rtl/a64_data_processing_imm_decoder_top.sv */
// Top level of the A64 data-processing immediate decoder: input register,
// single-pass decode logic and result register. Depends on a64dpi_pkg.
// An accepted item moves through the input register, then the result register.
// Throughput: one item per cycle while the output is not stalled; the decode
// between the registers is bounded by the 64-bit logical-immediate mask rotate.
// Reset clears the valid flags of both registers; payloads are not reset.
`default_nettype none

module a64_data_processing_imm_decoder_top import a64dpi_pkg::*; (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 s_axis_tvalid,
  output logic                s_axis_tready,
  input  wire  [InstrW-1:0]   s_axis_tdata,  // instruction[31:0]
  input  wire  [7:0]          s_axis_tuser,  // mode[2:0], zero fill above
  output logic                m_axis_tvalid,
  input  wire                 m_axis_tready,
  // valid_res[0], opcode[5:1], wide_operands[6], dest_reg[11:7],
  // first_src_reg[16:12], second_src_reg[21:17], immediate[85:22],
  // shift_amount[91:86], tag_offset[97:92], tag_adjust[101:98],
  // rotate_field[107:102], size_field[113:108], zero fill above
  output logic [OutDataW-1:0] m_axis_tdata
);

  logic              in_v_q;
  logic [ModeW-1:0]  mode_q;
  logic [InstrW-1:0] instr_q;
  logic              out_v_q;
  result_t           res_q;
  result_t           res_d;
  logic              out_rdy;
  bitmask_t          bm;

  assign out_rdy = !out_v_q || m_axis_tready;
  assign s_axis_tready = !in_v_q || out_rdy;
  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata = {(OutDataW - $bits(result_t))'(0), res_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (s_axis_tready) in_v_q <= s_axis_tvalid;
      if (out_rdy) out_v_q <= in_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      mode_q <= s_axis_tuser[ModeW-1:0];
      instr_q <= s_axis_tdata;
    end
    if (out_rdy && in_v_q) res_q <= res_d;
  end

  logic        sf;
  logic [1:0]  opc;
  logic        nbit;
  logic [5:0]  immr;
  logic [5:0]  imms;
  logic [1:0]  hw;
  logic [20:0] imm21;
  logic [ImmW-1:0] sext21;

  assign sf = instr_q[31];
  assign opc = instr_q[30:29];
  assign nbit = instr_q[22];
  assign immr = instr_q[21:16];
  assign imms = instr_q[15:10];
  assign hw = instr_q[22:21];
  assign imm21 = {instr_q[23:5], instr_q[30:29]};
  assign sext21 = {{(ImmW-21){imm21[20]}}, imm21};
  assign bm = decode_bit_masks(nbit, imms, immr, sf);

  always_comb begin
    res_d = '0;
    res_d.dest_reg = instr_q[4:0];
    case (mode_q)
      ModeAddr: begin
        res_d.valid_res = 1'b1;
        res_d.wide_operands = 1'b1;
        res_d.opcode = sf ? OpAdrp : OpAdr;
        res_d.immediate = sf ? (sext21 << 12) : sext21;
      end
      ModeAddSub: begin
        res_d.valid_res = 1'b1;
        res_d.opcode = OpAdd + {3'd0, opc};
        res_d.wide_operands = sf;
        res_d.first_src_reg = instr_q[9:5];
        res_d.immediate = {{(ImmW-12){1'b0}}, instr_q[21:10]};
        res_d.shift_amount = nbit ? AddSubShift : 6'd0;
      end
      ModeAddSubTag: begin
        if (sf && !instr_q[29] && !nbit) begin
          res_d.valid_res = 1'b1;
          res_d.opcode = instr_q[30] ? OpSubg : OpAddg;
          res_d.wide_operands = 1'b1;
          res_d.first_src_reg = instr_q[9:5];
          res_d.tag_offset = immr;
          res_d.tag_adjust = instr_q[13:10];
        end
      end
      ModeLogical: begin
        if (!(!sf && nbit) && bm.ok) begin
          res_d.valid_res = 1'b1;
          res_d.opcode = OpAnd + {3'd0, opc};
          res_d.wide_operands = sf;
          res_d.first_src_reg = instr_q[9:5];
          res_d.immediate = bm.mask;
        end
      end
      ModeMoveWide: begin
        if (opc != 2'd1 && !(!sf && hw[1])) begin
          res_d.valid_res = 1'b1;
          res_d.opcode = (opc == 2'd0) ? OpMovn : ((opc == 2'd2) ? OpMovz : OpMovk);
          res_d.wide_operands = sf;
          res_d.immediate = {{(ImmW-16){1'b0}}, instr_q[20:5]};
          res_d.shift_amount = {hw, 4'd0};
        end
      end
      ModeBitfield: begin
        if (sf == nbit && opc != 2'd3 && !(!sf && (immr[5] || imms[5]))) begin
          res_d.valid_res = 1'b1;
          res_d.opcode = OpSbfm + {3'd0, opc};
          res_d.wide_operands = sf;
          res_d.first_src_reg = instr_q[9:5];
          res_d.rotate_field = immr;
          res_d.size_field = imms;
        end
      end
      ModeExtract: begin
        if (sf == nbit && !instr_q[21] && opc == 2'd0 && !(!sf && imms[5])) begin
          res_d.valid_res = 1'b1;
          res_d.opcode = OpExtr;
          res_d.wide_operands = sf;
          res_d.first_src_reg = instr_q[9:5];
          res_d.second_src_reg = instr_q[20:16];
          res_d.size_field = imms;
        end
      end
      default: begin
        res_d.valid_res = 1'b0;
      end
    endcase
    if (!res_d.valid_res) res_d = '0;
  end

  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && !res_q.valid_res) |-> (res_q == '0))
    else $error("invalid result item carries nonzero fields");

  a_opcode_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && res_q.valid_res) |-> (res_q.opcode <= OpExtr))
    else $error("result opcode out of range");

  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (in_v_q && out_v_q && !m_axis_tready))
    else $error("input stalled while pipeline has room");

  a_accept_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> in_v_q)
    else $error("accepted item not held in input register");

  a_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_v_q && out_rdy) |=> out_v_q)
    else $error("decoded item did not reach result register");

endmodule

`default_nettype wire
